### hw/rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### hw/rtl/brkg_pkg.sv
`default_nettype none

package brkg_pkg;

    localparam int GS_W      = 7;
    localparam int DATA_W    = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [GS_W-1:0] GS_RESET = 7'd2;

    // register word index (paddr[2])
    localparam logic REG_GROUP_SIZE = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input beat taken, write store
        logic issue_rd;  // read next store entry
        logic load_out;  // move read data into output register
    } brkg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;      // accepted beat releases a group
        logic last_pend; // entry in flight is the final one of the run
        logic out_free;  // output register free at next edge
    } brkg_stat_t;

endpackage

`default_nettype wire

### hw/rtl/block_reverse_k_group_top.sv
// reverse-in-groups stream reorderer, one input beat accepted per idle cycle
// beat without release: stored, and the next beat may follow at once
// releasing beat: its run of results follows one by one, after the accept
// the input stalls until the last result of the run is loaded, longer while results stall
// (each result takes a store read then a load into the output register, never overlapped)
// reset (rst_n async, low): fill count cleared, held beats dropped, group_size = 2
`default_nettype none

`include "assert_macros.svh"

module block_reverse_k_group_top
    import brkg_pkg::*;
#(
    parameter int MAX_GROUP = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    // apb configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_AW-1:0]        paddr,
    input  wire logic [APB_DW-1:0]        pwdata,
    output logic      [APB_DW-1:0]        prdata,
    output logic                          pready,

    // input beats
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     end_of_list,

    // result beats
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      value_out,
    output logic                          run_last,
    output logic                          list_done
);

    logic [GS_W-1:0] group_size_reg;
    logic [GS_W-1:0] group_size_next;
    logic            cfg_wr;

    brkg_cmd_t  cmd;
    brkg_stat_t stat;

    // register file: a single word, group_size in the low bits
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        group_size_next = group_size_reg;
        if (cfg_wr && (paddr[2] == REG_GROUP_SIZE))
        begin
            group_size_next = pwdata[GS_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_GROUP_SIZE)
        begin
            prdata = {{(APB_DW-GS_W){1'b0}}, group_size_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GS_RESET;
        end
        else
        begin
            group_size_reg <= group_size_next;
        end
    end

    // sequencer: idle takes beats, read/load alternate to drain a run
    brkg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, pointers and output register
    brkg_dp #(
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .group_size  (group_size_reg),
        .value       (value),
        .end_of_list (end_of_list),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value_out   (value_out),
        .run_last    (run_last),
        .list_done   (list_done)
    );

    // a read is always followed by its load
    `ASSERT_CLK(a_rd_then_load, clk, rst_n, cmd.issue_rd |=> cmd.load_out, "read without load")
    // loading must never overwrite a pending result beat
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.load_out && out_valid, "result beat overwritten")
    // list end only on the closing beat of a run
    `ASSERT_NEVER(a_done_last, clk, rst_n, out_valid && list_done && !run_last, "list_done off run end")
    // input is never taken while a run drains
    `ASSERT_NEVER(a_no_accept_drain, clk, rst_n, cmd.accept && (cmd.issue_rd || cmd.load_out),
        "accept during drain")

endmodule

`default_nettype wire

### hw/rtl/brkg_ctrl.sv
`default_nettype none

module brkg_ctrl
    import brkg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire brkg_stat_t stat,
    output brkg_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.issue_rd = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && stat.emit)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.issue_rd = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = stat.last_pend ? S_IDLE : S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/brkg_dp.sv
`default_nettype none

module brkg_dp
    import brkg_pkg::*;
#(
    parameter int MAX_GROUP = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire brkg_cmd_t                cmd,
    input  wire logic [GS_W-1:0]          group_size,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     end_of_list,
    output brkg_stat_t                    stat,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      value_out,
    output logic                          run_last,
    output logic                          list_done
);

    localparam int PTR_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam logic [GS_W-1:0] K_MAX = GS_W'(MAX_GROUP);

    logic [DATA_W-1:0] store_mem [MAX_GROUP];
    logic [DATA_W-1:0] rdata_reg;

    logic [PTR_W-1:0] fill_reg;
    logic [PTR_W-1:0] fill_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic             down_reg;
    logic             down_next;
    logic             eol_reg;
    logic             eol_next;
    logic             last_pend_reg;
    logic             last_pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic [DATA_W-1:0] value_out_reg;
    logic              run_last_reg;
    logic              list_done_reg;

    logic [GS_W-1:0] k_eff;
    logic [GS_W-1:0] new_cnt;
    logic            full_group;

    // group size zero acts as one, above capacity saturates
    always_comb
    begin
        if (group_size == '0)
        begin
            k_eff = GS_W'(1);
        end
        else if (group_size > K_MAX)
        begin
            k_eff = K_MAX;
        end
        else
        begin
            k_eff = group_size;
        end
    end

    assign new_cnt    = GS_W'(fill_reg) + GS_W'(1);
    assign full_group = (new_cnt >= k_eff);

    assign stat.emit      = full_group || end_of_list;
    assign stat.last_pend = last_pend_reg;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        down_next      = down_reg;
        eol_next       = eol_reg;
        last_pend_next = last_pend_reg;
        out_valid_next = out_valid_reg;

        if (cmd.accept)
        begin
            if (full_group || end_of_list)
            begin
                // full group reads newest first, tail group in arrival order
                fill_next = '0;
                rem_next  = CNT_W'(new_cnt);
                ptr_next  = full_group ? fill_reg : '0;
                down_next = full_group;
                eol_next  = end_of_list;
            end
            else
            begin
                fill_next = fill_reg + PTR_W'(1);
            end
        end

        if (cmd.issue_rd)
        begin
            ptr_next       = down_reg ? (ptr_reg - PTR_W'(1)) : (ptr_reg + PTR_W'(1));
            rem_next       = rem_reg - CNT_W'(1);
            last_pend_next = (rem_reg == CNT_W'(1));
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            down_reg      <= 1'b0;
            eol_reg       <= 1'b0;
            last_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            down_reg      <= down_next;
            eol_reg       <= eol_next;
            last_pend_reg <= last_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // group store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            store_mem[fill_reg] <= value;
        end
        if (cmd.issue_rd)
        begin
            rdata_reg <= store_mem[ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value_out_reg <= rdata_reg;
            run_last_reg  <= last_pend_reg;
            list_done_reg <= last_pend_reg && eol_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign run_last  = run_last_reg;
    assign list_done = list_done_reg;

endmodule

`default_nettype wire
